@@ hw/rtl/jicw_pkg.sv @@
`default_nettype none

package jicw_pkg;

  localparam int unsigned IdW    = 24;
  localparam int unsigned BaseW  = 25;
  localparam int unsigned OutstW = 7;
  localparam int unsigned CntW   = 24;

  localparam logic [IdW-1:0]   JobTotalReset = 24'd999;
  localparam logic [BaseW-1:0] FirstId       = 25'd1;
  localparam logic [CntW-1:0]  CntMax        = {CntW{1'b1}};

  typedef enum logic {
    CMD_ACQUIRE  = 1'b0,
    CMD_REGISTER = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_RUN    = 2'd0,
    MODE_ERROR  = 2'd1,
    MODE_CANCEL = 2'd2
  } mode_e;

  typedef struct packed {
    logic granted;
    logic refused;
    logic bad_id;
    logic reg_ok;
  } jicw_evt_t;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    sat_inc = (v == CntMax) ? CntMax : v + CntW'(1);
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/jicw_window.sv @@
`default_nettype none

module jicw_window #(
  parameter int unsigned WINDOW_SLOTS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fire_i,
  input  jicw_pkg::cmd_e                cmd_i,
  input  logic [jicw_pkg::IdW-1:0]      job_id_i,
  input  jicw_pkg::mode_e               mode_i,
  input  logic [jicw_pkg::IdW-1:0]      job_total_i,
  output jicw_pkg::jicw_evt_t           evt_o,
  output logic [jicw_pkg::IdW-1:0]      grant_id_o,
  output logic [jicw_pkg::BaseW-1:0]    base_d_o,
  output logic [jicw_pkg::OutstW-1:0]   outst_d_o
);
  import jicw_pkg::*;

  localparam int unsigned LenW = $clog2(WINDOW_SLOTS + 1);
  localparam int unsigned IdxW = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;

  logic [BaseW-1:0]        next_id_q, next_id_d;
  logic [BaseW-1:0]        base_q, base_d;
  logic [LenW-1:0]         len_q, len_d;
  logic [LenW-1:0]         cnt_q, cnt_d;
  logic [WINDOW_SLOTS-1:0] bits_q, bits_d;

  logic [BaseW-1:0]        diff;
  logic [IdxW-1:0]         off;
  logic                    id_ok;
  logic [WINDOW_SLOTS-1:0] cleared;
  logic                    any_left;
  logic [IdxW-1:0]         first_set;
  logic [LenW-1:0]         pop_n;

  assign diff = {1'b0, job_id_i} - base_q;
  assign off  = diff[IdxW-1:0];
  assign id_ok = ({1'b0, job_id_i} >= base_q) && ({1'b0, job_id_i} < next_id_q)
               && (diff < BaseW'(len_q)) && bits_q[off];
  assign cleared = bits_q & ~(WINDOW_SLOTS'(1) << off);

  always_comb begin
    any_left  = 1'b0;
    first_set = '0;
    for (int i = WINDOW_SLOTS - 1; i >= 1; i--) begin
      if (cleared[i]) begin
        any_left  = 1'b1;
        first_set = IdxW'(i);
      end
    end
    pop_n = any_left ? LenW'(first_set) : len_q;
  end

  always_comb begin
    next_id_d  = next_id_q;
    base_d     = base_q;
    len_d      = len_q;
    cnt_d      = cnt_q;
    bits_d     = bits_q;
    evt_o      = '0;
    grant_id_o = '0;
    case (cmd_i)
      CMD_ACQUIRE: begin
        if (mode_i != MODE_RUN || next_id_q > {1'b0, job_total_i}
            || len_q >= LenW'(WINDOW_SLOTS)) begin
          evt_o.refused = 1'b1;
        end else begin
          evt_o.granted = 1'b1;
          grant_id_o    = next_id_q[IdW-1:0];
          bits_d        = bits_q | (WINDOW_SLOTS'(1) << len_q);
          len_d         = len_q + LenW'(1);
          cnt_d         = cnt_q + LenW'(1);
          next_id_d     = next_id_q + BaseW'(1);
        end
      end
      CMD_REGISTER: begin
        if (!id_ok) begin
          evt_o.bad_id = 1'b1;
        end else begin
          evt_o.reg_ok = 1'b1;
          cnt_d        = cnt_q - LenW'(1);
          if (off == '0) begin
            bits_d = cleared >> pop_n;
            len_d  = len_q - pop_n;
            base_d = base_q + BaseW'(pop_n);
          end else begin
            bits_d = cleared;
          end
        end
      end
      default: begin
        evt_o = '0;
      end
    endcase
  end

  assign base_d_o  = base_d;
  assign outst_d_o = OutstW'(cnt_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_id_q <= FirstId;
      base_q    <= FirstId;
      len_q     <= '0;
      cnt_q     <= '0;
      bits_q    <= '0;
    end else if (fire_i) begin
      next_id_q <= next_id_d;
      base_q    <= base_d;
      len_q     <= len_d;
      cnt_q     <= cnt_d;
      bits_q    <= bits_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/jicw_status.sv @@
`default_nettype none

module jicw_status (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        fire_i,
  input  logic                        reg_ok_i,
  input  logic                        failed_i,
  input  logic                        cancel_i,
  output jicw_pkg::mode_e             mode_o,
  output jicw_pkg::mode_e             mode_d_o,
  output logic [jicw_pkg::CntW-1:0]   ok_d_o,
  output logic [jicw_pkg::CntW-1:0]   err_d_o
);
  import jicw_pkg::*;

  mode_e           mode_q, mode_d;
  logic [CntW-1:0] ok_q, ok_d;
  logic [CntW-1:0] err_q, err_d;

  always_comb begin
    mode_d = mode_q;
    ok_d   = ok_q;
    err_d  = err_q;
    if (reg_ok_i) begin
      case (mode_q)
        MODE_RUN: begin
          if (failed_i) begin
            err_d  = sat_inc(err_q);
            mode_d = MODE_ERROR;
          end else if (cancel_i) begin
            mode_d = MODE_CANCEL;
          end else begin
            ok_d = sat_inc(ok_q);
          end
        end
        MODE_ERROR: begin
          if (failed_i) begin
            err_d = sat_inc(err_q);
          end
        end
        default: begin
          mode_d = mode_q;
        end
      endcase
    end
  end

  assign mode_o   = mode_q;
  assign mode_d_o = mode_d;
  assign ok_d_o   = ok_d;
  assign err_d_o  = err_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_RUN;
      ok_q   <= '0;
      err_q  <= '0;
    end else if (fire_i) begin
      mode_q <= mode_d;
      ok_q   <= ok_d;
      err_q  <= err_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/job_issue_completion_window.sv @@
// Channel   Valid          Stall          Payload
// in        in_valid_i     in_stall_o     command_i job_id_i job_failed_i cancel_requested_i
// out       out_valid_o    out_stall_i    granted_id_o refused_o bad_id_o oldest_pending_o
//                                         outstanding_o run_mode_o ok_count_o error_count_o
// cfg       cfg_we_i       -              cfg_wdata_i (job_total)
//
// One item per cycle while the input is not stalled; results leave the result register.
// The input register feeds one pass of window update (priority encode and shift
// over the pending bits) straight into the result register.
// Reset empties the window, sets the next id and window base to 1, job_total to 999.
// A stalled output holds the result; the input stalls only when both registers hold
// items and the output is stalled.
`default_nettype none

module job_issue_completion_window #(
  parameter int unsigned WINDOW_SLOTS = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [jicw_pkg::IdW-1:0]     cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         command_i,
  input  logic [jicw_pkg::IdW-1:0]     job_id_i,
  input  logic                         job_failed_i,
  input  logic                         cancel_requested_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [jicw_pkg::IdW-1:0]     granted_id_o,
  output logic                         refused_o,
  output logic                         bad_id_o,
  output logic [jicw_pkg::BaseW-1:0]   oldest_pending_o,
  output logic [jicw_pkg::OutstW-1:0]  outstanding_o,
  output logic [1:0]                   run_mode_o,
  output logic [jicw_pkg::CntW-1:0]    ok_count_o,
  output logic [jicw_pkg::CntW-1:0]    error_count_o
);
  import jicw_pkg::*;

  logic [IdW-1:0]    job_total_q;

  logic              s1_valid_q, s1_valid_d;
  cmd_e              s1_cmd_q;
  logic [IdW-1:0]    s1_id_q;
  logic              s1_failed_q;
  logic              s1_cancel_q;

  logic              out_valid_q, out_valid_d;
  logic [IdW-1:0]    grant_q;
  logic              refused_q;
  logic              bad_q;
  logic [BaseW-1:0]  base_q;
  logic [OutstW-1:0] outst_q;
  mode_e             mode_res_q;
  logic [CntW-1:0]   ok_q;
  logic [CntW-1:0]   err_q;

  logic              out_free;
  logic              s1_fire;
  logic              in_take;

  jicw_evt_t         evt;
  logic [IdW-1:0]    grant_id;
  logic [BaseW-1:0]  base_d;
  logic [OutstW-1:0] outst_d;
  mode_e             mode_cur;
  mode_e             mode_d;
  logic [CntW-1:0]   ok_d;
  logic [CntW-1:0]   err_d;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_take) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  jicw_window #(
    .WINDOW_SLOTS(WINDOW_SLOTS)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (s1_fire),
    .cmd_i       (s1_cmd_q),
    .job_id_i    (s1_id_q),
    .mode_i      (mode_cur),
    .job_total_i (job_total_q),
    .evt_o       (evt),
    .grant_id_o  (grant_id),
    .base_d_o    (base_d),
    .outst_d_o   (outst_d)
  );

  jicw_status u_status (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (s1_fire),
    .reg_ok_i (evt.reg_ok),
    .failed_i (s1_failed_q),
    .cancel_i (s1_cancel_q),
    .mode_o   (mode_cur),
    .mode_d_o (mode_d),
    .ok_d_o   (ok_d),
    .err_d_o  (err_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_total_q <= JobTotalReset;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        job_total_q <= cfg_wdata_i;
      end
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_cmd_q    <= cmd_e'(command_i);
      s1_id_q     <= job_id_i;
      s1_failed_q <= job_failed_i;
      s1_cancel_q <= cancel_requested_i;
    end
    if (s1_fire) begin
      grant_q    <= grant_id;
      refused_q  <= evt.refused;
      bad_q      <= evt.bad_id;
      base_q     <= base_d;
      outst_q    <= outst_d;
      mode_res_q <= mode_d;
      ok_q       <= ok_d;
      err_q      <= err_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign granted_id_o     = grant_q;
  assign refused_o        = refused_q;
  assign bad_id_o         = bad_q;
  assign oldest_pending_o = base_q;
  assign outstanding_o    = outst_q;
  assign run_mode_o       = mode_res_q;
  assign ok_count_o       = ok_q;
  assign error_count_o    = err_q;

endmodule

`default_nettype wire
